// ===== src/lsnh_pkg.sv =====
// Package with the transfer types and fixed constants of the link-state next-hop block.
`default_nettype none
package lsnh_pkg;

  localparam int NODE_W  = 6;
  localparam int LCOST_W = 16;
  localparam int OCOST_W = 24;
  localparam logic [OCOST_W-1:0] OUT_COST_MAX = 24'hFFFFFF;

  localparam logic OP_LINK  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [NODE_W-1:0]  node_a;
    logic [NODE_W-1:0]  node_b;
    logic               link_present;
    logic [LCOST_W-1:0] link_cost;
  } in_t;

  typedef struct packed {
    logic               reachable;
    logic [NODE_W-1:0]  next_hop;
    logic [OCOST_W-1:0] path_cost;
  } out_t;

endpackage
`default_nettype wire

// ===== src/link_state_next_hop.sv =====
// Top level of the link-state next-hop block: link memory, query scratch and control.
`default_nettype none
// The block holds a symmetric table of link costs in a synchronous memory and answers
// next-hop queries with Dijkstra's algorithm run from the destination. A link transfer
// makes one memory write per direction; a link naming a node at or past MAX_NODES is
// dropped. A query whose source or destination is not below the node count, or a self
// query, is answered straight from the idle state. Any other query first clears the
// per-node scratch memory and then settles one node per pass; each pass reads all n
// links of the settled node and all n scratch entries (n the node count) through the
// single read port of each memory, in three steps: the n reads, a drain of the read
// pipeline, and the write of the settled node. The minimum search runs inside the same
// pass as the relaxation. After reset the link memory is swept once, one entry per
// cycle, over all 2^(2*clog2(MAX_NODES)) entries (4096 by default), with busy high.
// Results appear on out_data for the single cycle in which out_valid is high; the
// receiver cannot stall, and start is taken only while busy is low.
module link_state_next_hop #(
  parameter int MAX_NODES = 64,
  parameter int COST_BITS = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  lsnh_pkg::in_t   in_data,
  output logic            out_valid,
  output lsnh_pkg::out_t  out_data
);

  import lsnh_pkg::*;

  localparam int NW     = $clog2(MAX_NODES);
  localparam int CW     = $clog2(MAX_NODES + 1);
  localparam int AW     = 2 * NW;
  localparam int LDEPTH = 1 << AW;
  localparam int SDEPTH = 1 << NW;
  localparam int XW     = (CW > NODE_W) ? CW : NODE_W;
  localparam int WW     = (COST_BITS > OCOST_W) ? COST_BITS : OCOST_W;

  typedef struct packed {
    logic                 valid;
    logic                 settled;
    logic [NW-1:0]        pred;
    logic [COST_BITS-1:0] cost;
  } scr_t;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_LINK2, S_INIT, S_RELAX} state_t;

  state_t               state_r;
  logic [AW-1:0]        clr_r;
  logic [CW-1:0]        node_cnt_r;
  logic [NW-1:0]        src_r, dst_r;
  logic [AW-1:0]        lk2_addr_r;
  logic [16:0]          lk_word_r;
  logic [CW-1:0]        cnt_r;
  logic [NW-1:0]        k_r;
  logic [COST_BITS-1:0] costk_r;
  logic                 p_v_r;
  logic [NW-1:0]        p_idx_r;
  logic                 found_r;
  logic [COST_BITS-1:0] best_r;
  logic [NW-1:0]        bpred_r;
  logic [NW-1:0]        pick_r;
  logic                 out_valid_r;
  out_t                 out_r;

  // Link memory: bit 16 is the present flag, bits 15:0 the cost.
  logic [16:0]   link_mem [LDEPTH];
  logic          lk_we;
  logic [AW-1:0] lk_waddr, lk_raddr;
  logic [16:0]   lk_wdata, lk_rdata_r;

  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[lk_waddr] <= lk_wdata;
    end
    lk_rdata_r <= link_mem[lk_raddr];
  end

  // Per-query scratch memory; every entry below the node count is written before use.
  scr_t          scr_mem [SDEPTH];
  logic          sc_we;
  logic [NW-1:0] sc_waddr, sc_raddr;
  scr_t          sc_wdata, sc_rdata_r;

  always_ff @(posedge clk) begin
    if (sc_we) begin
      scr_mem[sc_waddr] <= sc_wdata;
    end
    sc_rdata_r <= scr_mem[sc_raddr];
  end

  // Decode of the incoming transfer.
  logic          accept;
  logic [NW-1:0] ai, bi;
  logic          a_ok, b_ok, link_ok, q_in_range;
  logic [CW-1:0] na, nb, cnt_grow;

  assign accept     = start && (state_r == S_IDLE);
  assign ai         = NW'(in_data.node_a);
  assign bi         = NW'(in_data.node_b);
  assign a_ok       = XW'(in_data.node_a) < XW'(MAX_NODES);
  assign b_ok       = XW'(in_data.node_b) < XW'(MAX_NODES);
  assign link_ok    = a_ok && b_ok;
  assign q_in_range = (XW'(in_data.node_a) < XW'(node_cnt_r)) &&
                      (XW'(in_data.node_b) < XW'(node_cnt_r));
  assign na         = CW'(ai) + CW'(1);
  assign nb         = CW'(bi) + CW'(1);

  always_comb begin
    cnt_grow = node_cnt_r;
    if (na > cnt_grow) begin
      cnt_grow = na;
    end
    if (nb > cnt_grow) begin
      cnt_grow = nb;
    end
  end

  // Relaxation of the entry that came back from both memories this cycle.
  logic                 rx_valid, rx_cand;
  logic [NW-1:0]        rx_pred;
  logic [COST_BITS-1:0] rx_cost;

  lsnh_relax #(
    .NW        (NW),
    .COST_BITS (COST_BITS)
  ) u_relax (
    .k           (k_r),
    .cost_k      (costk_r),
    .lk_present  (lk_rdata_r[16]),
    .lk_cost     (lk_rdata_r[15:0]),
    .old_valid   (sc_rdata_r.valid),
    .old_settled (sc_rdata_r.settled),
    .old_pred    (sc_rdata_r.pred),
    .old_cost    (sc_rdata_r.cost),
    .new_valid   (rx_valid),
    .new_pred    (rx_pred),
    .new_cost    (rx_cost),
    .cand        (rx_cand)
  );

  logic issue, finish, take;
  logic [WW-1:0] best_x;

  assign issue  = (state_r == S_RELAX) && (cnt_r < node_cnt_r);
  assign finish = (state_r == S_RELAX) && (cnt_r == node_cnt_r) && !p_v_r;
  assign take   = p_v_r && rx_cand && (!found_r || rx_cost < best_r);
  assign best_x = WW'(best_r);

  // Memory port control.
  always_comb begin
    lk_raddr = {k_r, cnt_r[NW-1:0]};
    sc_raddr = cnt_r[NW-1:0];
    lk_we    = 1'b0;
    lk_waddr = lk2_addr_r;
    lk_wdata = lk_word_r;
    sc_we    = 1'b0;
    sc_waddr = p_idx_r;
    sc_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        lk_we    = 1'b1;
        lk_waddr = clr_r;
        lk_wdata = (clr_r[AW-1:NW] == clr_r[NW-1:0]) ? 17'h10000 : 17'h00000;
      end
      S_IDLE: begin
        lk_we    = accept && (in_data.operation == OP_LINK) && link_ok;
        lk_waddr = {ai, bi};
        lk_wdata = in_data.link_present ? {1'b1, in_data.link_cost} : 17'h00000;
      end
      S_LINK2: begin
        lk_we = 1'b1;
      end
      S_INIT: begin
        sc_we    = 1'b1;
        sc_waddr = cnt_r[NW-1:0];
        if (cnt_r[NW-1:0] == dst_r) begin
          sc_wdata.valid   = 1'b1;
          sc_wdata.settled = 1'b1;
        end
      end
      S_RELAX: begin
        if (p_v_r) begin
          sc_we            = 1'b1;
          sc_waddr         = p_idx_r;
          sc_wdata.valid   = rx_valid;
          sc_wdata.settled = sc_rdata_r.settled;
          sc_wdata.pred    = rx_pred;
          sc_wdata.cost    = rx_cost;
        end else if (finish && found_r) begin
          sc_we            = 1'b1;
          sc_waddr         = pick_r;
          sc_wdata.valid   = 1'b1;
          sc_wdata.settled = 1'b1;
          sc_wdata.pred    = bpred_r;
          sc_wdata.cost    = best_r;
        end
      end
      default: begin
        lk_we = 1'b0;
      end
    endcase
  end

  // Control state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      node_cnt_r  <= '0;
      cnt_r       <= '0;
      p_v_r       <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == {AW{1'b1}}) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (in_data.operation == OP_QUERY) begin
              if (!q_in_range) begin
                out_valid_r <= 1'b1;
                out_r       <= '0;
              end else if (in_data.node_a == in_data.node_b) begin
                out_valid_r     <= 1'b1;
                out_r.reachable <= 1'b1;
                out_r.next_hop  <= in_data.node_a;
                out_r.path_cost <= '0;
              end else begin
                src_r   <= ai;
                dst_r   <= bi;
                cnt_r   <= '0;
                state_r <= S_INIT;
              end
            end else if (link_ok) begin
              node_cnt_r <= cnt_grow;
              lk2_addr_r <= {bi, ai};
              lk_word_r  <= in_data.link_present ? {1'b1, in_data.link_cost} : 17'h00000;
              state_r    <= S_LINK2;
            end
          end
        end
        S_LINK2: begin
          state_r <= S_IDLE;
        end
        S_INIT: begin
          if (cnt_r == node_cnt_r - CW'(1)) begin
            cnt_r   <= '0;
            k_r     <= dst_r;
            costk_r <= '0;
            found_r <= 1'b0;
            p_v_r   <= 1'b0;
            state_r <= S_RELAX;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_RELAX: begin
          p_v_r   <= issue;
          p_idx_r <= cnt_r[NW-1:0];
          if (issue) begin
            cnt_r <= cnt_r + CW'(1);
          end
          if (take) begin
            found_r <= 1'b1;
            best_r  <= rx_cost;
            bpred_r <= rx_pred;
            pick_r  <= p_idx_r;
          end
          if (finish) begin
            if (!found_r) begin
              out_valid_r <= 1'b1;
              out_r       <= '0;
              state_r     <= S_IDLE;
            end else if (pick_r == src_r) begin
              out_valid_r     <= 1'b1;
              out_r.reachable <= 1'b1;
              out_r.next_hop  <= NODE_W'(bpred_r);
              out_r.path_cost <= (best_x > WW'(OUT_COST_MAX)) ? OUT_COST_MAX
                                                              : best_x[OCOST_W-1:0];
              state_r         <= S_IDLE;
            end else begin
              k_r     <= pick_r;
              costk_r <= best_r;
              cnt_r   <= '0;
              found_r <= 1'b0;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The read pipeline only carries entries while a relaxation pass runs.
  a_pipe_in_relax: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r |-> (state_r == S_RELAX))
    else $error("relax pipeline active outside a pass");

  // An unreachable answer carries zero hop and zero cost.
  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.reachable) |-> (out_r.next_hop == '0 && out_r.path_cost == '0))
    else $error("unreachable result with nonzero fields");

  // A result only follows a finished query, never a pass still in flight.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result presented while busy");

  // The link sweep after reset keeps the block from taking transfers.
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |=> ($past(clr_r) == {AW{1'b1}} || busy))
    else $error("block idle during link sweep");

endmodule
`default_nettype wire

// ===== src/lsnh_relax.sv =====
// Relaxation of one node over a link out of the newly settled node.
`default_nettype none
module lsnh_relax #(
  parameter int NW        = 6,
  parameter int COST_BITS = 24
) (
  input  logic [NW-1:0]        k,
  input  logic [COST_BITS-1:0] cost_k,
  input  logic                 lk_present,
  input  logic [15:0]          lk_cost,
  input  logic                 old_valid,
  input  logic                 old_settled,
  input  logic [NW-1:0]        old_pred,
  input  logic [COST_BITS-1:0] old_cost,
  output logic                 new_valid,
  output logic [NW-1:0]        new_pred,
  output logic [COST_BITS-1:0] new_cost,
  output logic                 cand
);

  localparam int SW = ((COST_BITS > 16) ? COST_BITS : 16) + 1;
  localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

  logic [SW-1:0]        sum;
  logic [COST_BITS-1:0] sat;

  assign sum = SW'(cost_k) + SW'(lk_cost);
  assign sat = (sum > SW'(COST_MAX)) ? COST_MAX : COST_BITS'(sum);

  always_comb begin
    new_valid = old_valid;
    new_pred  = old_pred;
    new_cost  = old_cost;
    if (lk_present && !old_settled) begin
      if (!old_valid || sat < old_cost) begin
        new_valid = 1'b1;
        new_pred  = k;
        new_cost  = sat;
      end else if (sat == old_cost && k < old_pred) begin
        new_pred = k;
      end
    end
  end

  // A node competes for the next settle only if it is open and has a cost.
  assign cand = !old_settled && new_valid;

endmodule
`default_nettype wire
